### design/hemisphere_depth_splat_buffer_defines.svh
// Assertion macros shared by the splat buffer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef HEMISPHERE_DEPTH_SPLAT_BUFFER_DEFINES_SVH
`define HEMISPHERE_DEPTH_SPLAT_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
`define HDSB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HDSB_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HDSB_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDSB_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### design/hdsb_pkg.sv
// Shared types and constants for the hemisphere depth splat buffer.
// No dependencies; used by the front, queue, back and top level.
package hdsb_pkg;

    localparam int GRID_SIDE_DEF  = 32;
    localparam int MAX_RADIUS_DEF = 7;

    // coordinate width covers the widest clamp range of any legal parameter set
    localparam int COORD_W = 10;
    localparam int RAD_W   = 5;

    localparam logic [31:0] DEPTH_FAR  = 32'hFFFF_FFFF;
    localparam logic [31:0] NODE_RESET = 32'd938461273;
    localparam logic [15:0] SCALE_ONE  = 16'd256;
    localparam int          BLEND_SHIFT = 4;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_OCCLUDE = 3'd1,
        CMD_MIN     = 3'd2,
        CMD_MIN_ID  = 3'd3,
        CMD_BLEND   = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        JOB_NONE  = 2'd0,
        JOB_CLEAR = 2'd1,
        JOB_SPLAT = 2'd2,
        JOB_READ  = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind                  kind;
        t_cmd                       cmd;
        logic signed [COORD_W-1:0]  cs;
        logic signed [COORD_W-1:0]  ct;
        logic [RAD_W-1:0]           rad;
        logic [31:0]                dep;
        logic [31:0]                node;
        logic [15:0]                scl;
    } t_job;

endpackage

### design/hemisphere_depth_splat_buffer.sv
// Hemisphere depth splat buffer: a GRID_SIDE x GRID_SIDE grid of depth, node and scale
// cells addressed by a stereographic map of a point or ray in a configurable local frame.
// The front maps each item with 9 projection and 3 square multiplies on one shared
// multiplier, a 26-step square root and two bit-serial divides, each with a setup step.
// The back then reads and writes back each cell of a splat (read-modify-write), up to
// (2*MAX_RADIUS+1)^2 cells, looks up a single cell for a read and sweeps every cell for
// a clear. After reset the back sweeps all GRID_SIDE*GRID_SIDE cells before it serves its
// first item; configuration writes are taken at once. A two-entry queue lets the front
// accept and work on the next item during a splat. Depends on hdsb_pkg, hdsb_front,
// hdsb_fifo and hdsb_back.
module hemisphere_depth_splat_buffer #(
    parameter int GRID_SIDE  = hdsb_pkg::GRID_SIDE_DEF,
    parameter int MAX_RADIUS = hdsb_pkg::MAX_RADIUS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [47:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // cmd[2:0], pos_x[18:3], pos_y[34:19], pos_z[50:35], depth_in[82:51],
    // node_in[114:83], scale_in[130:115], splat_radius[133:131], zero[135:134]
    input  logic [135:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // depth_out[31:0], node_out[63:32], scale_out[79:64], accepted[80], zero[87:81]
    output logic [87:0]   m_axis_tdata
);

    logic            w_push, w_full, w_pop, w_empty;
    hdsb_pkg::t_job  w_fjob, w_bjob;
    logic [31:0]     w_depth, w_node;
    logic [15:0]     w_scale;
    logic            w_acc;

    hdsb_front #(
        .GRID_SIDE  (GRID_SIDE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tdata[2:0]),
        .i_pos_x    (s_axis_tdata[18:3]),
        .i_pos_y    (s_axis_tdata[34:19]),
        .i_pos_z    (s_axis_tdata[50:35]),
        .i_depth    (s_axis_tdata[82:51]),
        .i_node     (s_axis_tdata[114:83]),
        .i_scale    (s_axis_tdata[130:115]),
        .i_radius   (s_axis_tdata[133:131]),
        .o_push     (w_push),
        .o_job      (w_fjob),
        .i_full     (w_full)
    );

    hdsb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_bjob),
        .o_empty (w_empty)
    );

    hdsb_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_job      (w_bjob),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_depth    (w_depth),
        .o_node     (w_node),
        .o_scale    (w_scale),
        .o_accepted (w_acc)
    );

    assign m_axis_tdata = {7'b0, w_acc, w_scale, w_node, w_depth};

endmodule

### design/hdsb_fifo.sv
// Two-entry job queue between the front and the back of the splat buffer.
// Depends on hdsb_pkg for the job type and on the assertion macro header.
`include "hemisphere_depth_splat_buffer_defines.svh"
module hdsb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hdsb_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output hdsb_pkg::t_job  o_data,
    output logic            o_empty
);

    hdsb_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    `HDSB_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `HDSB_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `HDSB_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3, "queue count out of range")

endmodule

### design/hdsb_front.sv
// Front end: accepts items, moves them into the local frame and maps them to a cell.
// One shared multiplier, an iterative square root and a shared bit-serial divider.
// Depends on hdsb_pkg.
module hdsb_front #(
    parameter int GRID_SIDE  = hdsb_pkg::GRID_SIDE_DEF,
    parameter int MAX_RADIUS = hdsb_pkg::MAX_RADIUS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [47:0]     i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_cmd,
    input  logic [15:0]     i_pos_x,
    input  logic [15:0]     i_pos_y,
    input  logic [15:0]     i_pos_z,
    input  logic [31:0]     i_depth,
    input  logic [31:0]     i_node,
    input  logic [15:0]     i_scale,
    input  logic [2:0]      i_radius,
    output logic            o_push,
    output hdsb_pkg::t_job  o_job,
    input  logic            i_full
);

    localparam int HALF_SIDE = GRID_SIDE / 2;
    localparam int D_W    = 26;
    localparam int MUL_W  = 2 * D_W;
    localparam int ACC_W  = 34;
    localparam int SQ_W   = MUL_W;
    localparam int RT_W   = SQ_W / 2;
    localparam int RM_W   = RT_W + 2;
    localparam int DEN_W  = RT_W + 1;
    localparam int ND_W   = DEN_W + 2;
    localparam int HS_W   = $clog2(HALF_SIDE) + 1;
    localparam int NUM_W  = ND_W + HS_W;
    localparam int MAG_W  = NUM_W - 1;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam int CW     = hdsb_pkg::COORD_W;
    localparam int RW     = hdsb_pkg::RAD_W;

    localparam logic signed [NUM_W-1:0] HALF_S = NUM_W'(HALF_SIDE);
    localparam logic signed [MAG_W:0]   WR_LO  = (MAG_W+1)'(-(MAX_RADIUS + 1));
    localparam logic signed [MAG_W:0]   WR_HI  = (MAG_W+1)'(GRID_SIDE + MAX_RADIUS);
    localparam logic signed [MAG_W:0]   RD_HI  = (MAG_W+1)'(GRID_SIDE - 1);
    localparam logic [RW-1:0]           RAD_MAX = RW'(MAX_RADIUS);

    typedef enum logic [7:0] {
        F_IDLE = 8'b0000_0001,
        F_PROJ = 8'b0000_0010,
        F_SQ   = 8'b0000_0100,
        F_ROOT = 8'b0000_1000,
        F_DEN  = 8'b0001_0000,
        F_DSET = 8'b0010_0000,
        F_DIV  = 8'b0100_0000,
        F_PUSH = 8'b1000_0000
    } t_fstate;

    t_fstate                 r_state;
    logic [47:0]             r_origin, r_tan, r_bin, r_nrm;
    hdsb_pkg::t_cmd          r_cmd;
    hdsb_pkg::t_job_kind     r_kind;
    logic [31:0]             r_dep, r_node;
    logic [15:0]             r_scl;
    logic [RW-1:0]           r_rad;
    logic signed [16:0]      r_rv [3];
    logic signed [D_W-1:0]   r_d [3];
    logic [1:0]              r_comp, r_axis;
    logic                    r_ph;
    logic signed [MUL_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [SQ_W-1:0]         r_sq;
    logic [RM_W-1:0]         r_rem;
    logic [RT_W-1:0]         r_root;
    logic [CNT_W-1:0]        r_cnt;
    logic [DEN_W-1:0]        r_den;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic [DEN_W:0]          r_drem;
    logic [MAG_W-1:0]        r_q;
    logic                    r_dsel;
    logic signed [CW-1:0]    r_cs, r_ct;

    logic [47:0]             w_axis;
    logic signed [15:0]      w_af;
    logic signed [D_W-1:0]   w_ma, w_mb;
    logic signed [MUL_W-1:0] w_prod;
    logic signed [ACC_W-1:0] w_psum;
    logic signed [D_W-1:0]   w_pd;
    logic [RM_W-1:0]         w_rsh, w_trial;
    logic signed [DEN_W:0]   w_dens;
    logic signed [D_W-1:0]   w_dc;
    logic signed [ND_W-1:0]  w_ndc;
    logic signed [NUM_W-1:0] w_num;
    logic [DEN_W:0]          w_dsh;
    logic                    w_qbit;
    logic [MAG_W-1:0]        w_qn;
    logic signed [MAG_W:0]   w_qs, w_qc, w_lo, w_hi;
    logic                    w_reject;
    logic signed [16:0]      w_px, w_py, w_pz;
    logic signed [16:0]      w_ox, w_oy, w_oz;

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_job      = '0;
        o_job.kind = r_kind;
        o_job.cmd  = r_cmd;
        o_job.cs   = r_cs;
        o_job.ct   = r_ct;
        o_job.rad  = r_rad;
        o_job.dep  = r_dep;
        o_job.node = r_node;
        o_job.scl  = r_scl;
    end

    // shared multiplier: projection terms, then squares of the local components
    always_comb begin
        case (r_axis)
            2'd0:    w_axis = r_tan;
            2'd1:    w_axis = r_bin;
            default: w_axis = r_nrm;
        endcase
        case (r_comp)
            2'd0:    w_af = signed'(w_axis[15:0]);
            2'd1:    w_af = signed'(w_axis[31:16]);
            default: w_af = signed'(w_axis[47:32]);
        endcase
        if (r_state == F_SQ) begin
            w_ma = r_d[r_comp];
            w_mb = r_d[r_comp];
        end else begin
            w_ma = D_W'(r_rv[r_comp]);
            w_mb = D_W'(w_af);
        end
        w_prod = w_ma * w_mb;
    end

    assign w_psum = r_acc + ACC_W'(r_prod);
    assign w_pd   = D_W'(w_psum >>> 8);
    assign w_reject = w_pd[D_W-1] &&
        (r_cmd inside {hdsb_pkg::CMD_OCCLUDE, hdsb_pkg::CMD_MIN, hdsb_pkg::CMD_MIN_ID});

    assign w_rsh   = {r_rem[RM_W-3:0], r_sq[SQ_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};

    assign w_dens = signed'({1'b0, r_root}) + (DEN_W+1)'(r_d[2]);

    assign w_dc   = r_dsel ? r_d[1] : r_d[0];
    assign w_ndc  = signed'({2'b00, r_den}) + ND_W'(w_dc);
    assign w_num  = NUM_W'(w_ndc) * HALF_S;

    assign w_dsh  = {r_drem[DEN_W-1:0], r_mag[MAG_W-1]};
    assign w_qbit = (w_dsh >= {1'b0, r_den});
    assign w_qn   = {r_q[MAG_W-2:0], w_qbit};

    // truncate toward zero, then clamp to the write or read window
    always_comb begin
        w_qs = r_neg ? -signed'({1'b0, w_qn}) : signed'({1'b0, w_qn});
        if (r_kind == hdsb_pkg::JOB_READ) begin
            w_lo = '0;
            w_hi = RD_HI;
        end else begin
            w_lo = WR_LO;
            w_hi = WR_HI;
        end
        if (w_qs < w_lo)      w_qc = w_lo;
        else if (w_qs > w_hi) w_qc = w_hi;
        else                  w_qc = w_qs;
    end

    assign w_px = 17'(signed'(i_pos_x));
    assign w_py = 17'(signed'(i_pos_y));
    assign w_pz = 17'(signed'(i_pos_z));

    // rays are not moved by the origin
    always_comb begin
        if (i_cmd == hdsb_pkg::CMD_READ) begin
            w_ox = '0;
            w_oy = '0;
            w_oz = '0;
        end else begin
            w_ox = 17'(signed'(r_origin[15:0]));
            w_oy = 17'(signed'(r_origin[31:16]));
            w_oz = 17'(signed'(r_origin[47:32]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_tan    <= '0;
            r_bin    <= '0;
            r_nrm    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                2'd0:    r_origin <= i_cfg_data;
                2'd1:    r_tan    <= i_cfg_data;
                2'd2:    r_bin    <= i_cfg_data;
                default: r_nrm    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_cmd  <= hdsb_pkg::t_cmd'(i_cmd);
                        r_dep  <= i_depth;
                        r_node <= i_node;
                        r_scl  <= i_scale;
                        r_rad  <= (RW'(i_radius) > RAD_MAX) ? RAD_MAX : RW'(i_radius);
                        r_cs   <= '0;
                        r_ct   <= '0;
                        r_acc  <= '0;
                        r_sq   <= '0;
                        r_comp <= 2'd0;
                        r_axis <= 2'd0;
                        r_ph   <= 1'b0;
                        r_dsel <= 1'b0;
                        r_rv[0] <= w_px - w_ox;
                        r_rv[1] <= w_py - w_oy;
                        r_rv[2] <= w_pz - w_oz;
                        case (hdsb_pkg::t_cmd'(i_cmd))
                            hdsb_pkg::CMD_CLEAR: begin
                                r_kind  <= hdsb_pkg::JOB_CLEAR;
                                r_state <= F_PUSH;
                            end
                            hdsb_pkg::CMD_READ: begin
                                r_kind  <= hdsb_pkg::JOB_READ;
                                r_state <= F_PROJ;
                            end
                            hdsb_pkg::CMD_OCCLUDE, hdsb_pkg::CMD_MIN,
                            hdsb_pkg::CMD_MIN_ID, hdsb_pkg::CMD_BLEND: begin
                                r_kind  <= hdsb_pkg::JOB_SPLAT;
                                r_state <= F_PROJ;
                            end
                            default: begin
                                r_kind  <= hdsb_pkg::JOB_NONE;
                                r_state <= F_PUSH;
                            end
                        endcase
                    end
                end
                F_PROJ: begin
                    r_ph <= ~r_ph;
                    if (!r_ph) begin
                        r_prod <= w_prod;
                    end else if (r_comp == 2'd2) begin
                        r_d[r_axis] <= w_pd;
                        r_acc  <= '0;
                        r_comp <= 2'd0;
                        if (r_axis == 2'd2) begin
                            // below the horizon: drop for the plain write commands
                            if (w_reject) begin
                                r_kind  <= hdsb_pkg::JOB_NONE;
                                r_state <= F_PUSH;
                            end else begin
                                r_state <= F_SQ;
                            end
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_acc  <= w_psum;
                        r_comp <= r_comp + 2'd1;
                    end
                end
                F_SQ: begin
                    r_ph <= ~r_ph;
                    if (!r_ph) begin
                        r_prod <= w_prod;
                    end else begin
                        r_sq <= r_sq + SQ_W'(unsigned'(r_prod));
                        if (r_comp == 2'd2) begin
                            r_comp  <= 2'd0;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= F_ROOT;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end
                end
                F_ROOT: begin
                    r_sq <= r_sq << 2;
                    if (w_rsh >= w_trial) begin
                        r_rem  <= w_rsh - w_trial;
                        r_root <= {r_root[RT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rsh;
                        r_root <= {r_root[RT_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(RT_W - 1)) r_state <= F_DEN;
                end
                F_DEN: begin
                    // degenerate direction: force the denominator to one
                    r_den   <= (w_dens < 1) ? DEN_W'(1) : DEN_W'(w_dens);
                    r_state <= F_DSET;
                end
                F_DSET: begin
                    r_neg   <= w_num[NUM_W-1];
                    r_mag   <= MAG_W'(w_num[NUM_W-1] ? -w_num : w_num);
                    r_drem  <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    r_mag <= r_mag << 1;
                    r_q   <= w_qn;
                    r_drem <= w_qbit ? (w_dsh - {1'b0, r_den}) : w_dsh;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAG_W - 1)) begin
                        if (!r_dsel) begin
                            r_cs    <= CW'(w_qc);
                            r_dsel  <= 1'b1;
                            r_state <= F_DSET;
                        end else begin
                            r_ct    <= CW'(w_qc);
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

### design/hdsb_back.sv
// Back end: cell memories, clearing pass, splat walk with read-modify-write, reads.
// Holds the output register. Depends on hdsb_pkg and the assertion macro header.
`include "hemisphere_depth_splat_buffer_defines.svh"
module hdsb_back #(
    parameter int GRID_SIDE = hdsb_pkg::GRID_SIDE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  hdsb_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_depth,
    output logic [31:0]     o_node,
    output logic [15:0]     o_scale,
    output logic            o_accepted
);

    localparam int NCELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW     = $clog2(NCELLS);
    localparam int IW     = $clog2(GRID_SIDE);
    localparam int BW     = hdsb_pkg::COORD_W + 1;
    localparam logic [AW-1:0]        SIDE_A  = AW'(GRID_SIDE);
    localparam logic [AW-1:0]        LAST_A  = AW'(NCELLS - 1);
    localparam logic signed [BW-1:0] SIDE_M1 = BW'(GRID_SIDE - 1);

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_RD    = 5'b00100,
        B_WR    = 5'b01000,
        B_RES   = 5'b10000
    } t_bstate;

    logic [31:0] m_dep  [NCELLS];
    logic [31:0] m_node [NCELLS];
    logic [15:0] m_scl  [NCELLS];

    t_bstate         r_state;
    logic [AW-1:0]   r_caddr;
    logic            r_clr_job;
    hdsb_pkg::t_job  r_job;
    logic [IW-1:0]   r_i, r_j, r_ilo, r_ihi, r_jhi;
    logic [31:0]     r_rd_dep, r_rd_node;
    logic [15:0]     r_rd_scl;
    logic [31:0]     r_res_dep, r_res_node;
    logic [15:0]     r_res_scl;
    logic            r_res_acc;
    logic            r_out_valid;
    logic [31:0]     r_o_dep, r_o_node;
    logic [15:0]     r_o_scl;
    logic            r_o_acc;

    logic [AW-1:0]         w_addr, w_waddr;
    logic                  w_we_dep, w_we_ext;
    logic [31:0]           w_wdep, w_wnode;
    logic [15:0]           w_wscl;
    logic                  w_out_load;
    logic signed [BW-1:0]  w_rad, w_ilo, w_ihi, w_jlo, w_jhi;
    logic                  w_empty_box;
    logic                  w_closer, w_near;
    logic [32:0]           w_sum;
    logic [IW-1:0]         w_i0, w_j0;

    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign w_out_load = (r_state == B_RES) && (!r_out_valid || i_ready);
    assign o_valid    = r_out_valid;
    assign o_depth    = r_o_dep;
    assign o_node     = r_o_node;
    assign o_scale    = r_o_scl;
    assign o_accepted = r_o_acc;

    assign w_addr = AW'(r_j) * SIDE_A + AW'(r_i);

    // clip the splat square to the grid
    always_comb begin
        w_rad = BW'(signed'({1'b0, i_job.rad}));
        w_ilo = BW'(i_job.cs) - w_rad;
        w_ihi = BW'(i_job.cs) + w_rad;
        w_jlo = BW'(i_job.ct) - w_rad;
        w_jhi = BW'(i_job.ct) + w_rad;
        if (w_ilo < 0)       w_ilo = '0;
        if (w_jlo < 0)       w_jlo = '0;
        if (w_ihi > SIDE_M1) w_ihi = SIDE_M1;
        if (w_jhi > SIDE_M1) w_jhi = SIDE_M1;
        w_empty_box = (w_ilo > w_ihi) || (w_jlo > w_jhi);
    end

    // a read starts on its own cell, a splat on the corner of its box
    assign w_i0 = (i_job.kind == hdsb_pkg::JOB_READ) ? IW'(i_job.cs) : IW'(w_ilo);
    assign w_j0 = (i_job.kind == hdsb_pkg::JOB_READ) ? IW'(i_job.ct) : IW'(w_jlo);

    assign w_closer = (r_job.dep < r_rd_dep);
    assign w_near   = (36'(r_rd_dep) < (36'(r_job.dep) << hdsb_pkg::BLEND_SHIFT));
    assign w_sum    = {1'b0, r_rd_dep} + {1'b0, r_job.dep};

    always_comb begin
        w_waddr  = w_addr;
        w_we_dep = 1'b0;
        w_we_ext = 1'b0;
        w_wdep   = r_job.dep;
        w_wnode  = r_job.node;
        w_wscl   = r_job.scl;
        if (r_state == B_CLEAR) begin
            w_waddr  = r_caddr;
            w_we_dep = 1'b1;
            w_we_ext = 1'b1;
            w_wdep   = hdsb_pkg::DEPTH_FAR;
            w_wnode  = hdsb_pkg::NODE_RESET;
            w_wscl   = hdsb_pkg::SCALE_ONE;
        end else if (r_state == B_WR && r_job.kind == hdsb_pkg::JOB_SPLAT) begin
            case (r_job.cmd)
                hdsb_pkg::CMD_OCCLUDE: begin
                    w_we_dep = 1'b1;
                    w_wdep   = '0;
                end
                hdsb_pkg::CMD_MIN: begin
                    w_we_dep = w_closer;
                end
                hdsb_pkg::CMD_MIN_ID: begin
                    w_we_dep = w_closer;
                    w_we_ext = w_closer;
                end
                hdsb_pkg::CMD_BLEND: begin
                    w_we_dep = w_closer;
                    w_we_ext = w_closer;
                    // average only when the old depth is within the blend ratio
                    if (w_near) w_wdep = w_sum[32:1];
                end
                default: begin
                    w_we_dep = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_dep  <= m_dep[w_addr];
        r_rd_node <= m_node[w_addr];
        r_rd_scl  <= m_scl[w_addr];
        if (w_we_dep) m_dep[w_waddr] <= w_wdep;
        if (w_we_ext) begin
            m_node[w_waddr] <= w_wnode;
            m_scl[w_waddr]  <= w_wscl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_dep  <= r_res_dep;
            r_o_node <= r_res_node;
            r_o_scl  <= r_res_scl;
            r_o_acc  <= r_res_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_caddr     <= '0;
            r_clr_job   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load)   r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            case (r_state)
                B_CLEAR: begin
                    r_caddr <= (r_caddr == LAST_A) ? '0 : r_caddr + AW'(1);
                    if (r_caddr == LAST_A) begin
                        r_state <= r_clr_job ? B_RES : B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job      <= i_job;
                        r_res_dep  <= '0;
                        r_res_node <= '0;
                        r_res_scl  <= '0;
                        r_res_acc  <= (i_job.kind != hdsb_pkg::JOB_NONE);
                        r_ilo      <= IW'(w_ilo);
                        r_ihi      <= IW'(w_ihi);
                        r_jhi      <= IW'(w_jhi);
                        r_i        <= w_i0;
                        r_j        <= w_j0;
                        case (i_job.kind)
                            hdsb_pkg::JOB_CLEAR: begin
                                r_clr_job <= 1'b1;
                                r_state   <= B_CLEAR;
                            end
                            hdsb_pkg::JOB_READ: begin
                                r_state <= B_RD;
                            end
                            hdsb_pkg::JOB_SPLAT: begin
                                r_state <= w_empty_box ? B_RES : B_RD;
                            end
                            default: begin
                                r_state <= B_RES;
                            end
                        endcase
                    end
                end
                B_RD: begin
                    r_state <= B_WR;
                end
                B_WR: begin
                    if (r_job.kind == hdsb_pkg::JOB_READ) begin
                        r_res_dep  <= r_rd_dep;
                        r_res_node <= r_rd_node;
                        r_res_scl  <= r_rd_scl;
                        r_state    <= B_RES;
                    end else if (r_i == r_ihi) begin
                        r_i <= r_ilo;
                        if (r_j == r_jhi) begin
                            r_state <= B_RES;
                        end else begin
                            r_j     <= r_j + IW'(1);
                            r_state <= B_RD;
                        end
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= B_RD;
                    end
                end
                B_RES: begin
                    if (w_out_load) begin
                        r_clr_job <= 1'b0;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `HDSB_NEVER(a_no_write_idle, i_clk, i_rst_n, (w_we_dep || w_we_ext) && r_state == B_IDLE, "cell write while idle")
    `HDSB_NEVER(a_walk_in_box, i_clk, i_rst_n, r_state == B_WR && r_job.kind == hdsb_pkg::JOB_SPLAT && (r_i > r_ihi || r_j > r_jhi), "splat walk left its box")
    `HDSB_NEVER(a_pop_only_idle, i_clk, i_rst_n, o_pop && r_state != B_IDLE, "queue pop outside idle")
    `HDSB_ASSERT(a_load_sets_valid, i_clk, i_rst_n, w_out_load |=> r_out_valid, "result load lost")

endmodule
